[hw/rtl/kmst_pkg.sv]
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants of the spanning tree weight unit.
// ----------------------------------------------------------------------------
`default_nettype none
package kmst_pkg;

   localparam int MAX_EDGES    = 1024;
   localparam int EADDR_W      = $clog2(MAX_EDGES);
   localparam int ECNT_W       = EADDR_W + 1;
   localparam int MAX_VERTICES = 256;
   localparam int VADDR_W      = $clog2(MAX_VERTICES);
   localparam int VCNT_W       = VADDR_W + 1;
   localparam int WEIGHT_BITS  = 16;
   localparam int SUM_W        = 24;
   localparam int EDGE_W       = 2 * VADDR_W + WEIGHT_BITS;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 40;
   localparam logic [VCNT_W-1:0] VC_RESET = VCNT_W'(MAX_VERTICES);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_CHECK,
      ST_SCAN,
      ST_PICK,
      ST_FA_RD,
      ST_FA_CHK,
      ST_FB_RD,
      ST_FB_CHK,
      ST_UNION,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic init_clr;
      logic init_wr;
      logic scan_clr;
      logic scan_run;
      logic pick;
      logic find_rd;
      logic fa_chk;
      logic fb_chk;
      logic take;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic init_done;
      logic scan_done;
      logic have_best;
      logic stop;
      logic skip;
      logic root_found;
      logic rsp_busy;
   } sts_type;

endpackage
`default_nettype wire

[hw/rtl/kmst_ram.sv]
// ----------------------------------------------------------------------------
// kmst_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module kmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/kmst_ctrl.sv]
// ----------------------------------------------------------------------------
// kmst_ctrl
// Sequencer: load, parent init, min scans, root finds and union steps.
// ----------------------------------------------------------------------------
`default_nettype none
module kmst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tlast,
   output logic                   req_tready,
   input  wire kmst_pkg::sts_type sts,
   output kmst_pkg::cmd_type      cmd
);

   kmst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmst_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         kmst_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_tlast) begin
                  cmd.init_clr = 1'b1;
                  state_in     = kmst_pkg::ST_INIT;
               end
            end
         end
         kmst_pkg::ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.init_done) state_in = kmst_pkg::ST_CHECK;
         end
         kmst_pkg::ST_CHECK: begin
            if (sts.stop) begin
               state_in = kmst_pkg::ST_DONE;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = kmst_pkg::ST_SCAN;
            end
         end
         kmst_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = sts.have_best ? kmst_pkg::ST_PICK : kmst_pkg::ST_DONE;
            end
         end
         kmst_pkg::ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = sts.skip ? kmst_pkg::ST_CHECK : kmst_pkg::ST_FA_RD;
         end
         kmst_pkg::ST_FA_RD: begin
            cmd.find_rd = 1'b1;
            state_in    = kmst_pkg::ST_FA_CHK;
         end
         kmst_pkg::ST_FA_CHK: begin
            cmd.fa_chk = 1'b1;
            state_in   = sts.root_found ? kmst_pkg::ST_FB_RD : kmst_pkg::ST_FA_RD;
         end
         kmst_pkg::ST_FB_RD: begin
            cmd.find_rd = 1'b1;
            state_in    = kmst_pkg::ST_FB_CHK;
         end
         kmst_pkg::ST_FB_CHK: begin
            cmd.fb_chk = 1'b1;
            state_in   = sts.root_found ? kmst_pkg::ST_UNION : kmst_pkg::ST_FB_RD;
         end
         kmst_pkg::ST_UNION: begin
            cmd.take = 1'b1;
            state_in = kmst_pkg::ST_CHECK;
         end
         kmst_pkg::ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = kmst_pkg::ST_LOAD;
            end
         end
         default: state_in = kmst_pkg::ST_LOAD;
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/kmst_dpath.sv]
// ----------------------------------------------------------------------------
// kmst_dpath
// Edge store, parent table, scan compare, find and sum registers.
// ----------------------------------------------------------------------------
`default_nettype none
module kmst_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire kmst_pkg::cmd_type                   cmd,
   output kmst_pkg::sts_type                        sts,
   input  wire logic [kmst_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                csr_wen,
   input  wire logic [kmst_pkg::VCNT_W-1:0]         csr_wdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [kmst_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int VW = kmst_pkg::VADDR_W;
   localparam int WB = kmst_pkg::WEIGHT_BITS;
   localparam int AW = kmst_pkg::EADDR_W;
   localparam int CW = kmst_pkg::ECNT_W;
   localparam int NW = kmst_pkg::VCNT_W;
   localparam int SW = kmst_pkg::SUM_W;

   logic [NW-1:0]        vc_ff;
   logic [CW-1:0]        count_ff;
   logic                 ovf_ff;
   logic [SW-1:0]        sum_ff;
   logic [VW-1:0]        taken_ff;
   logic [VW-1:0]        init_ff;
   logic [CW-1:0]        scan_ff;
   logic                 dv_ff;
   logic [AW-1:0]        didx_ff;
   logic                 have_best_ff;
   logic [AW-1:0]        best_idx_ff;
   logic signed [WB-1:0] best_w_ff;
   logic [VW-1:0]        best_from_ff, best_to_ff;
   logic                 have_prev_ff;
   logic [AW-1:0]        prev_idx_ff;
   logic signed [WB-1:0] prev_w_ff;
   logic [VW-1:0]        x_ff, ra_ff, rb_ff;
   logic                 rsp_valid_ff;
   logic [kmst_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [kmst_pkg::EDGE_W-1:0] edge_rd;
   logic [VW-1:0]               par_rd;
   logic                        edge_wr_en, edge_rd_en;
   logic                        par_wr_en;
   logic [VW-1:0]               par_wr_addr, par_wr_data;
   logic [VW-1:0]               d_from, d_to;
   logic signed [WB-1:0]        d_w;
   logic                        gt_prev, lt_best, cand;
   logic [NW-1:0]               vc_m1;
   logic                        spanning;

   assign edge_wr_en = cmd.accept && (count_ff < CW'(kmst_pkg::MAX_EDGES));
   assign edge_rd_en = cmd.scan_run && (scan_ff < count_ff);

   kmst_ram #(.WIDTH(kmst_pkg::EDGE_W), .DEPTH(kmst_pkg::MAX_EDGES)) u_edges (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata[kmst_pkg::EDGE_W-1:0]),
      .rd_en   (edge_rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (edge_rd)
   );

   // parent table: init sweep and union share the write port
   assign par_wr_en   = cmd.init_wr || (cmd.take && (ra_ff != rb_ff));
   assign par_wr_addr = cmd.init_wr ? init_ff : ra_ff;
   assign par_wr_data = cmd.init_wr ? init_ff : rb_ff;

   kmst_ram #(.WIDTH(VW), .DEPTH(kmst_pkg::MAX_VERTICES)) u_parent (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (par_wr_addr),
      .wr_data (par_wr_data),
      .rd_en   (cmd.find_rd),
      .rd_addr (x_ff),
      .rd_data (par_rd)
   );

   assign d_from = edge_rd[VW-1:0];
   assign d_to   = edge_rd[2*VW-1:VW];
   assign d_w    = edge_rd[2*VW+WB-1:2*VW];

   // key order is (weight, arrival index)
   assign gt_prev = !have_prev_ff || (d_w > prev_w_ff) ||
                    ((d_w == prev_w_ff) && (didx_ff > prev_idx_ff));
   assign lt_best = !have_best_ff || (d_w < best_w_ff) ||
                    ((d_w == best_w_ff) && (didx_ff < best_idx_ff));
   assign cand    = dv_ff && gt_prev && lt_best;

   assign vc_m1    = vc_ff - NW'(1);
   assign spanning = (vc_ff != '0) && ({1'b0, taken_ff} == vc_m1);

   always_comb begin
      sts            = '0;
      sts.init_done  = (init_ff == '1);
      sts.scan_done  = (scan_ff == count_ff) && !dv_ff;
      sts.have_best  = have_best_ff;
      sts.stop       = spanning || (vc_ff == '0);
      sts.skip       = ({1'b0, best_from_ff} >= vc_ff) || ({1'b0, best_to_ff} >= vc_ff);
      sts.root_found = (par_rd == x_ff);
      sts.rsp_busy   = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= kmst_pkg::VC_RESET;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         taken_ff     <= '0;
         dv_ff        <= 1'b0;
         have_best_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) vc_ff <= csr_wdata;
         if (cmd.accept) begin
            if (edge_wr_en) count_ff <= count_ff + CW'(1);
            else            ovf_ff   <= 1'b1;
         end
         if (cmd.init_clr) have_prev_ff <= 1'b0;
         if (cmd.scan_clr) begin
            have_best_ff <= 1'b0;
            dv_ff        <= 1'b0;
         end else if (cmd.scan_run) begin
            dv_ff <= edge_rd_en;
            if (cand) have_best_ff <= 1'b1;
         end
         if (cmd.pick) have_prev_ff <= 1'b1;
         if (cmd.take && (ra_ff != rb_ff)) begin
            sum_ff   <= sum_ff + SW'(best_w_ff);
            taken_ff <= taken_ff + VW'(1);
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= '0;
            ovf_ff       <= 1'b0;
            sum_ff       <= '0;
            taken_ff     <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.init_clr) init_ff <= '0;
      else if (cmd.init_wr) init_ff <= init_ff + VW'(1);
      if (cmd.scan_clr) begin
         scan_ff <= '0;
      end else if (cmd.scan_run) begin
         if (edge_rd_en) scan_ff <= scan_ff + CW'(1);
         didx_ff <= scan_ff[AW-1:0];
         if (cand) begin
            best_idx_ff  <= didx_ff;
            best_w_ff    <= d_w;
            best_from_ff <= d_from;
            best_to_ff   <= d_to;
         end
      end
      if (cmd.pick) begin
         prev_idx_ff <= best_idx_ff;
         prev_w_ff   <= best_w_ff;
         x_ff        <= best_from_ff;
      end
      if (cmd.fa_chk) begin
         if (par_rd == x_ff) begin
            ra_ff <= x_ff;
            x_ff  <= best_to_ff;
         end else begin
            x_ff <= par_rd;
         end
      end
      if (cmd.fb_chk) begin
         if (par_rd == x_ff) rb_ff <= x_ff;
         else                x_ff  <= par_rd;
      end
      if (cmd.finish) begin
         rsp_data_ff <= {6'd0, ovf_ff, spanning, taken_ff, sum_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

[hw/rtl/kruskal_mst_weight_unit.sv]
// ----------------------------------------------------------------------------
// kruskal_mst_weight_unit
// Minimum spanning forest weight of a streamed edge list, Kruskal method.
// ----------------------------------------------------------------------------
// Edges load at one item per cycle in the load state into a 1024-entry edge
// RAM. After the last edge: parent table init over all 256 entries, then per
// candidate edge a check, a scan of all stored edges for the next smallest
// (weight, arrival) key, a pick, a read and a check per vertex on each root
// find, and one union step. Result is registered after the walk when no
// result waits; one graph at a time. Sync high reset clears counts, vc = 256.
// ----------------------------------------------------------------------------
`default_nettype none
module kruskal_mst_weight_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: edge_from[7:0], edge_to[15:8], edge_weight[31:16]
   input  wire logic [kmst_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tlast,   // last_edge
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rsp_tdata: total_weight[23:0], edges_taken[31:24], spanning[32],
   //            overflow[33], zero pad[39:34]
   output logic      [kmst_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // vertex_count register
   input  wire logic                                csr_wen,
   input  wire logic [kmst_pkg::VCNT_W-1:0]         csr_wdata
);

   kmst_pkg::cmd_type cmd;
   kmst_pkg::sts_type sts;

   // controller sequences the walk
   kmst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath holds stores, compare and accumulators
   kmst_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
